// ===== hdl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way sorted merge block: request codes,
// field widths, controller states and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int REQ_TYPE_W   = 1;
  localparam int LIST_INDEX_W = 3;
  localparam int VALUE_W      = 32;
  localparam int NUM_LISTS_W  = 4;

  localparam logic [NUM_LISTS_W-1:0] NUM_LISTS_RST = 4'd8;

  localparam logic [REQ_TYPE_W-1:0] REQ_PUSH = 1'b0;
  localparam logic [REQ_TYPE_W-1:0] REQ_POP  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SCAN,
    S_FIN,
    S_DONE
  } kwm_state_t;

  typedef struct packed {
    logic load;    // capture the accepted item, start a new scan
    logic push;    // append the captured value
    logic scan;    // look at one list head this cycle
    logic finish;  // load the result register and advance the winning head
  } kwm_cmd_t;

  typedef struct packed {
    logic scan_last;  // current scan step is the last one
    logic out_ready;  // result register can take a new item
  } kwm_status_t;

endpackage

// ===== hdl/k_way_sorted_merge_top.sv =====
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// Merge of up to MAX_LISTS sorted lists: push appends to a list, pop returns
// the smallest unread head across the first num_lists lists.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A push is written in the S_PUSH state
// after acceptance. A pop takes L scan steps, where L is num_lists saturated
// at MAX_LISTS, with at least one scan step when num_lists is zero: the
// list store has one read port, and the scan reads one list head from it per
// cycle, compares it in the next cycle and then loads the result register. A
// finished result waits in that register while the next item is accepted; a
// pop does not complete until the register is free. Storage is
// MAX_LISTS * LIST_DEPTH words of DATA_WIDTH bits; there is no clearing pass
// after reset. A push to a full list drops the value and sets the sticky
// overflow flag; a push to a list index at or above MAX_LISTS is ignored.
module k_way_sorted_merge_top
  import kwm_pkg::*;
#(
  parameter int MAX_LISTS  = 8,
  parameter int LIST_DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [REQ_TYPE_W-1:0]     req_type,
  input  logic [LIST_INDEX_W-1:0]   list_index,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic signed [VALUE_W-1:0] min_value,
  output logic                      all_empty,
  output logic                      overflow_seen,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [NUM_LISTS_W-1:0]    cfg_data
);

  kwm_cmd_t    cmd;
  kwm_status_t status;

  assign cfg_ready = 1'b1;

  kwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status)
  );

  kwm_dp #(
    .MAX_LISTS  (MAX_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .list_index    (list_index),
    .value         (value),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .min_value     (min_value),
    .all_empty     (all_empty),
    .overflow_seen (overflow_seen),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

// ===== hdl/kwm_ram.sv =====
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/kwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for the merge block: takes one item at a time, runs a push in one
// step or a pop as a scan over the list heads, then hands the result over.
// ----------------------------------------------------------------------------
module kwm_ctrl
  import kwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [REQ_TYPE_W-1:0] req_type,
  output logic                  req_stall,
  output kwm_cmd_t              cmd,
  input  kwm_status_t           status
);

  kwm_state_t state;
  kwm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req_type == REQ_POP) ? S_SCAN : S_PUSH;
        end
      end
      S_PUSH: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (status.scan_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_FIN: begin
        cmd = '0;
      end
      S_DONE: begin
        cmd.finish = status.out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // a result is only produced when the output register can take it
  a_finish_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_ready)
    else $error("finish without room in result register");

endmodule

// ===== hdl/kwm_dp.sv =====
// ----------------------------------------------------------------------------
// kwm_dp
// Datapath of the merge block: list store, per-list write counts and read
// heads, the scan compare stage, overflow flag and the result register.
// ----------------------------------------------------------------------------
module kwm_dp
  import kwm_pkg::*;
#(
  parameter int MAX_LISTS  = 8,
  parameter int LIST_DEPTH = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [LIST_INDEX_W-1:0]        list_index,
  input  logic signed [VALUE_W-1:0]      value,
  input  logic                           cfg_valid,
  input  logic [NUM_LISTS_W-1:0]         cfg_data,
  output logic signed [VALUE_W-1:0]      min_value,
  output logic                           all_empty,
  output logic                           overflow_seen,
  output logic                           res_valid,
  input  logic                           res_stall,
  input  kwm_cmd_t                       cmd,
  output kwm_status_t                    status
);

  localparam int IW = $clog2(MAX_LISTS);
  localparam int LW = $clog2(MAX_LISTS + 1);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int MD = MAX_LISTS * LIST_DEPTH;
  localparam int AW = $clog2(MD);

  logic [NUM_LISTS_W-1:0]    num_lists;
  logic [LIST_INDEX_W-1:0]   idx_q;
  logic signed [VALUE_W-1:0] value_q;

  logic [CW-1:0] counts [MAX_LISTS];
  logic [CW-1:0] heads  [MAX_LISTS];
  logic          overflow_flag;

  logic [LW-1:0] lim;
  logic [LW-1:0] scan_i;
  logic [IW-1:0] sel_idx;
  logic [CW-1:0] count_sel;
  logic [CW-1:0] head_sel;
  logic [CW-1:0] ofs;
  logic [AW-1:0] addr;
  logic          idx_ok;
  logic          full;
  logic          issue;

  logic signed [63:0]    push_ext;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  p_valid;
  logic [IW-1:0]         p_idx;
  logic                  found;
  logic [IW-1:0]         best_idx;
  logic [DATA_WIDTH-1:0] best_val;
  logic signed [63:0]    best_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lists <= NUM_LISTS_RST;
    end else if (cfg_valid) begin
      num_lists <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_q   <= list_index;
      value_q <= value;
    end
  end

  always_comb begin
    if (32'(num_lists) > MAX_LISTS) begin
      lim = LW'(MAX_LISTS);
    end else begin
      lim = LW'(num_lists);
    end
  end

  // one lookup port into counts and heads, shared by push and scan
  assign sel_idx   = cmd.push ? IW'(idx_q) : scan_i[IW-1:0];
  assign count_sel = counts[sel_idx];
  assign head_sel  = heads[sel_idx];
  assign ofs       = cmd.push ? count_sel : head_sel;
  assign addr      = AW'(sel_idx) * AW'(LIST_DEPTH) + AW'(ofs);

  assign idx_ok = {{(32 - LIST_INDEX_W){1'b0}}, idx_q} < 32'(MAX_LISTS);
  assign full   = count_sel == CW'(LIST_DEPTH);
  assign issue  = cmd.scan && (scan_i < lim) && (head_sel < count_sel);

  assign push_ext  = 64'(value_q);
  assign push_data = push_ext[DATA_WIDTH-1:0];

  kwm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MD)
  ) u_store (
    .clk   (clk),
    .we    (cmd.push && idx_ok && !full),
    .waddr (addr),
    .wdata (push_data),
    .re    (issue),
    .raddr (addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        counts[i] <= '0;
        heads[i]  <= '0;
      end
      overflow_flag <= 1'b0;
    end else begin
      if (cmd.push && idx_ok) begin
        if (full) begin
          overflow_flag <= 1'b1;
        end else begin
          counts[sel_idx] <= count_sel + CW'(1);
        end
      end
      if (cmd.finish && found) begin
        heads[best_idx] <= heads[best_idx] + CW'(1);
      end
    end
  end

  // scan step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
    end else if (cmd.load) begin
      scan_i <= '0;
    end else if (cmd.scan) begin
      scan_i <= scan_i + LW'(1);
    end
  end

  assign status.scan_last = ((LW + 1)'(scan_i) + (LW + 1)'(1)) >= (LW + 1)'(lim);

  // compare stage, in the cycle after the memory read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      p_valid <= issue;
      if (cmd.load) begin
        found <= 1'b0;
      end else if (p_valid) begin
        // strict less keeps the lower list on a tie
        if (!found || ($signed(rd_data) < $signed(best_val))) begin
          found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx <= scan_i[IW-1:0];
    end
    if (p_valid && (!found || ($signed(rd_data) < $signed(best_val)))) begin
      best_idx <= p_idx;
      best_val <= rd_data;
    end
  end

  assign best_ext = 64'($signed(best_val));

  // result register
  assign status.out_ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      min_value     <= found ? best_ext[VALUE_W-1:0] : '0;
      all_empty     <= !found;
      overflow_seen <= overflow_flag;
    end
  end

  a_full_sets_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.push && idx_ok && full |=> overflow_flag)
    else $error("push to full list did not set overflow");

  a_head_le_count: assert property (@(posedge clk) disable iff (rst)
    head_sel <= count_sel)
    else $error("read head passed write count");

  a_read_from_scan: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(cmd.scan))
    else $error("compare stage fed outside a scan");

endmodule
